>>> rtl/ncdf_pkg.sv
// ----------------------------------------------------------------------------
// ncdf_pkg
// Shared types, fixed-point constants and pipeline depths for the normal
// CDF datapath.
// ----------------------------------------------------------------------------
package ncdf_pkg;

  typedef logic signed [15:0] z_t;     // Q4.12 standard score
  typedef logic [26:0]        x_t;     // |z|/sqrt(2), Q.24
  typedef logic [25:0]        den_t;   // 1 + p*x, Q.24
  typedef logic [24:0]        t_t;     // 1/den, Q.24
  typedef logic [29:0]        x2_t;    // x*x, Q.24
  typedef logic signed [26:0] acc_t;   // Horner accumulator, Q.24
  typedef logic [25:0]        q0_t;    // P(t)*t clamped, Q.24
  typedef logic [32:0]        e_t;     // exp(-x*x), Q1.32

  typedef struct packed {
    logic vld;
    logic neg;
  } side_t;

  typedef struct packed {
    logic               vld;
    logic [5:0]         n;
    logic [31:0]        r32;
    logic signed [34:0] sum;
  } exp_ctx_t;

  localparam logic [23:0] INV_SQRT2 = 24'd11863283;
  localparam logic [22:0] P_COEF    = 23'd5496067;
  localparam logic [23:0] LN2_Q24   = 24'd11629080;
  localparam logic [25:0] ONE_Q24   = 26'h100_0000;
  localparam logic [23:0] HALF_Q24  = 24'h80_0000;

  localparam acc_t POLY_LEAD = 27'sd17807428;
  localparam int   POLY_STEPS = 5;
  localparam acc_t POLY_ADD [POLY_STEPS] = '{
    -27'sd24379845, 27'sd23847365, -27'sd4773063, 27'sd4275331, 27'sd0
  };

  localparam int TAYLOR_TERMS = 12;
  localparam int NDIV_BITS    = 6;
  localparam int EXP_ZERO_N   = 40;

  localparam int FRONT_LAT = 3;
  localparam int RECIP_LAT = 25;
  localparam int POLY_LAT  = 2 * POLY_STEPS;
  localparam int EXP_LAT   = NDIV_BITS + 3 * TAYLOR_TERMS + 1;
  localparam int ALIGN_LAT = EXP_LAT - RECIP_LAT - POLY_LAT;
  localparam int TOTAL_LAT = FRONT_LAT + EXP_LAT + 2;

endpackage

>>> rtl/ncdf_front.sv
// ----------------------------------------------------------------------------
// ncdf_front
// Absolute value, scale by 1/sqrt(2), then form 1 + p*x and x*x.
// ----------------------------------------------------------------------------
module ncdf_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  ncdf_pkg::z_t    z_value,
  output ncdf_pkg::side_t side,
  output ncdf_pkg::den_t  den,
  output ncdf_pkg::x2_t   x2
);
  import ncdf_pkg::*;

  logic [FRONT_LAT-1:0] vld_r;
  logic [FRONT_LAT-1:0] neg_r;
  logic [16:0]          abs_r;
  x_t                   x24_r;
  den_t                 den_r;
  x2_t                  x2_r;

  logic [16:0] abs_nxt;
  logic [40:0] xprod;
  logic [49:0] pprod;
  logic [53:0] sq;

  always_comb begin
    abs_nxt = z_value[15] ? (17'h10000 - {1'b0, z_value}) : {1'b0, z_value};
    xprod   = 41'(abs_r) * 41'(INV_SQRT2) + 41'd2048;
    pprod   = 50'(x24_r) * 50'(P_COEF) + 50'(HALF_Q24);
    sq      = 54'(x24_r) * 54'(x24_r) + 54'(HALF_Q24);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[FRONT_LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    neg_r <= {neg_r[FRONT_LAT-2:0], z_value[15]};
    abs_r <= abs_nxt;
    x24_r <= x_t'(xprod >> 12);
    den_r <= den_t'(50'(ONE_Q24) + (pprod >> 24));
    x2_r  <= x2_t'(sq >> 24);
  end

  assign side.vld = vld_r[FRONT_LAT-1];
  assign side.neg = neg_r[FRONT_LAT-1];
  assign den      = den_r;
  assign x2       = x2_r;

endmodule

>>> rtl/ncdf_recip.sv
// ----------------------------------------------------------------------------
// ncdf_recip
// Pipelined restoring divider: t = round(2^48 / den), one quotient bit
// per stage.
// ----------------------------------------------------------------------------
module ncdf_recip (
  input  logic           clk,
  input  ncdf_pkg::den_t den,
  output ncdf_pkg::t_t   t_out
);
  import ncdf_pkg::*;

  logic [25:0] rem_r  [RECIP_LAT];
  t_t          quo_r  [RECIP_LAT];
  den_t        den_r  [RECIP_LAT];
  logic [24:0] low_r  [RECIP_LAT];

  for (genvar i = 0; i < RECIP_LAT; i++) begin : g_stage
    logic [25:0] rem_in;
    t_t          quo_in;
    den_t        den_in;
    logic [24:0] low_in;
    logic [26:0] trial;
    logic        ge;

    if (i == 0) begin : g_first
      // numerator is 2^48 + den/2; its upper bits reduce to 2^23
      assign rem_in = 26'h80_0000;
      assign quo_in = '0;
      assign den_in = den;
      assign low_in = 25'(den >> 1);
    end else begin : g_next
      assign rem_in = rem_r[i-1];
      assign quo_in = quo_r[i-1];
      assign den_in = den_r[i-1];
      assign low_in = low_r[i-1];
    end

    assign trial = {rem_in, low_in[RECIP_LAT-1-i]};
    assign ge    = trial >= {1'b0, den_in};

    always_ff @(posedge clk) begin
      rem_r[i] <= ge ? 26'(trial - {1'b0, den_in}) : 26'(trial);
      quo_r[i] <= {quo_in[RECIP_LAT-2:0], ge};
      den_r[i] <= den_in;
      low_r[i] <= low_in;
    end
  end

  assign t_out = quo_r[RECIP_LAT-1];

endmodule

>>> rtl/ncdf_poly.sv
// ----------------------------------------------------------------------------
// ncdf_poly
// Horner evaluation of the fifth-order polynomial times t, two stages per
// coefficient: multiply magnitude, then round, restore sign and add.
// ----------------------------------------------------------------------------
module ncdf_poly (
  input  logic          clk,
  input  ncdf_pkg::t_t  t_in,
  output ncdf_pkg::q0_t q0
);
  import ncdf_pkg::*;

  logic        neg_r  [POLY_STEPS];
  logic [51:0] prod_r [POLY_STEPS];
  t_t          ta_r   [POLY_STEPS];
  t_t          tb_r   [POLY_STEPS];
  acc_t        acc_r  [POLY_STEPS];

  for (genvar k = 0; k < POLY_STEPS; k++) begin : g_step
    acc_t        acc_in;
    t_t          t_k;
    logic [26:0] mag;
    logic [26:0] p;

    if (k == 0) begin : g_first
      assign acc_in = POLY_LEAD;
      assign t_k    = t_in;
    end else begin : g_next
      assign acc_in = acc_r[k-1];
      assign t_k    = tb_r[k-1];
    end

    assign mag = acc_in[26] ? 27'(-acc_in) : 27'(acc_in);
    assign p   = 27'((prod_r[k] + 52'(HALF_Q24)) >> 24);

    always_ff @(posedge clk) begin
      neg_r[k]  <= acc_in[26];
      prod_r[k] <= 52'(mag) * 52'(t_k);
      ta_r[k]   <= t_k;
      acc_r[k]  <= (neg_r[k] ? -$signed(p) : $signed(p)) + POLY_ADD[k];
      tb_r[k]   <= ta_r[k];
    end
  end

  // drop negative results to zero
  assign q0 = acc_r[POLY_STEPS-1][26] ? '0 : q0_t'(acc_r[POLY_STEPS-1][25:0]);

endmodule

>>> rtl/ncdf_exp.sv
// ----------------------------------------------------------------------------
// ncdf_exp
// exp(-v) in Q1.32: range reduction by ln2, a 12-term Taylor series with
// three stages per term, and a final rounding shift by n.
// ----------------------------------------------------------------------------
module ncdf_exp (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  ncdf_pkg::x2_t v_in,
  output logic          out_valid,
  output ncdf_pkg::e_t  e_out
);
  import ncdf_pkg::*;

  logic        dv_r   [NDIV_BITS];
  logic [29:0] drem_r [NDIV_BITS];
  logic [5:0]  dn_r   [NDIV_BITS];

  exp_ctx_t    ca_r   [TAYLOR_TERMS];
  exp_ctx_t    cb_r   [TAYLOR_TERMS];
  exp_ctx_t    cc_r   [TAYLOR_TERMS];
  logic [64:0] prod_r [TAYLOR_TERMS];
  logic [32:0] w_r    [TAYLOR_TERMS];
  logic [68:0] est_r  [TAYLOR_TERMS];
  logic [32:0] term_r [TAYLOR_TERMS];

  logic vld_r;
  e_t   e_r;

  // n = floor(v / ln2), one bit per stage
  for (genvar j = 0; j < NDIV_BITS; j++) begin : g_ndiv
    localparam logic [29:0] SUB = 30'(LN2_Q24) << (NDIV_BITS - 1 - j);
    logic        vld_in;
    logic [29:0] rem_in;
    logic [5:0]  n_in;
    logic        ge;

    if (j == 0) begin : g_first
      assign vld_in = in_valid;
      assign rem_in = v_in;
      assign n_in   = '0;
    end else begin : g_next
      assign vld_in = dv_r[j-1];
      assign rem_in = drem_r[j-1];
      assign n_in   = dn_r[j-1];
    end

    assign ge = rem_in >= SUB;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[j] <= 1'b0;
      end else begin
        dv_r[j] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      drem_r[j] <= ge ? rem_in - SUB : rem_in;
      dn_r[j]   <= n_in | (6'(ge) << (NDIV_BITS - 1 - j));
    end
  end

  for (genvar k = 0; k < TAYLOR_TERMS; k++) begin : g_term
    localparam logic [3:0]  KV      = 4'(k + 1);
    localparam logic [35:0] RECIP_M = (36'd1 << 35) / 36'(k + 1);
    exp_ctx_t    ctx_in;
    exp_ctx_t    ctx_c;
    logic [32:0] term_in;
    logic [32:0] w_nxt;
    logic [33:0] qe;
    logic [33:0] qfix;
    logic [37:0] left;

    if (k == 0) begin : g_first
      assign ctx_in.vld = dv_r[NDIV_BITS-1];
      assign ctx_in.n   = dn_r[NDIV_BITS-1];
      assign ctx_in.r32 = {drem_r[NDIV_BITS-1][23:0], 8'd0};
      assign ctx_in.sum = 35'sh1_0000_0000;
      assign term_in    = 33'h1_0000_0000;
    end else begin : g_next
      assign ctx_in  = cc_r[k-1];
      assign term_in = term_r[k-1];
    end

    assign w_nxt = 33'((prod_r[k] + 65'h8000_0000) >> 32);

    // reciprocal estimate is low by at most one; fix with one compare
    always_comb begin
      qe    = 34'(est_r[k] >> 35);
      left  = 38'(w_r[k]) - 38'(qe) * 38'(KV);
      qfix  = (left >= 38'(KV)) ? qe + 34'd1 : qe;
      ctx_c = cb_r[k];
      if ((k % 2) == 0) begin
        ctx_c.sum = cb_r[k].sum - $signed(35'(qfix));
      end else begin
        ctx_c.sum = cb_r[k].sum + $signed(35'(qfix));
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ca_r[k] <= '0;
        cb_r[k] <= '0;
        cc_r[k] <= '0;
      end else begin
        ca_r[k] <= ctx_in;
        cb_r[k] <= ca_r[k];
        cc_r[k] <= ctx_c;
      end
    end

    always_ff @(posedge clk) begin
      prod_r[k] <= 65'(term_in) * 65'(ctx_in.r32);
      w_r[k]    <= w_nxt;
      est_r[k]  <= 69'(w_nxt) * 69'(RECIP_M);
      term_r[k] <= 33'(qfix);
    end
  end

  exp_ctx_t    fin;
  logic [32:0] sum_c;
  logic [39:0] half;
  logic [39:0] shv;

  always_comb begin
    fin   = cc_r[TAYLOR_TERMS-1];
    sum_c = fin.sum[34] ? '0 : 33'(fin.sum);
    half  = (fin.n == 6'd0) ? '0 : (40'd1 << 6'(fin.n - 6'd1));
    shv   = (40'(sum_c) + half) >> fin.n;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= fin.vld;
    end
  end

  always_ff @(posedge clk) begin
    e_r <= (fin.n >= 6'(EXP_ZERO_N)) ? '0 : e_t'(shv);
  end

  assign out_valid = vld_r;
  assign e_out     = e_r;

endmodule

>>> rtl/normal_cdf_approx.sv
// ----------------------------------------------------------------------------
// normal_cdf_approx
// Standard normal CDF of a Q4.12 score, returned as saturated Q0.16.
// ----------------------------------------------------------------------------
// A start transfer runs through the front stages, the exp unit, then fvld_r and strobe_r to out_strobe.
// Throughput: one z per cycle; busy stays low, the pipeline never stalls.
// Depth is set by the exp unit (6 range-reduction stages, 3 per Taylor term).
// Reset clears all valid bits; no result appears for items in flight.
module normal_cdf_approx (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  ncdf_pkg::z_t  in_z_value,
  output logic          out_strobe,
  output logic [15:0]   out_probability
);
  import ncdf_pkg::*;

  side_t side;
  den_t  den;
  x2_t   x2;
  t_t    t_val;
  q0_t   q0;
  logic  e_vld;
  e_t    e_val;

  q0_t                q0_dly_r  [ALIGN_LAT];
  logic [EXP_LAT-1:0] neg_dly_r;
  logic [58:0]        fprod_r;
  logic               fneg_r;
  logic               fvld_r;
  logic               strobe_r;
  logic [15:0]        prob_r;

  logic [25:0] qv;
  logic [17:0] h;
  logic [17:0] res;

  ncdf_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (start),
    .z_value  (in_z_value),
    .side     (side),
    .den      (den),
    .x2       (x2)
  );

  ncdf_recip u_recip (
    .clk   (clk),
    .den   (den),
    .t_out (t_val)
  );

  ncdf_poly u_poly (
    .clk  (clk),
    .t_in (t_val),
    .q0   (q0)
  );

  ncdf_exp u_exp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (side.vld),
    .v_in      (x2),
    .out_valid (e_vld),
    .e_out     (e_val)
  );

  // hold the polynomial and the sign until exp catches up
  always_ff @(posedge clk) begin
    q0_dly_r[0] <= q0;
    for (int i = 1; i < ALIGN_LAT; i++) begin
      q0_dly_r[i] <= q0_dly_r[i-1];
    end
    neg_dly_r <= {neg_dly_r[EXP_LAT-2:0], side.neg};
    fprod_r   <= 59'(q0_dly_r[ALIGN_LAT-1]) * 59'(e_val);
    fneg_r    <= neg_dly_r[EXP_LAT-1];
    prob_r    <= 16'(res);
  end

  always_comb begin
    qv = 26'((fprod_r + 59'h8000_0000) >> 32);
    h  = 18'((27'(qv) + 27'd256) >> 9);
    if (fneg_r) begin
      res = h;
    end else if (h >= 18'h10000) begin
      res = '0;
    end else begin
      res = 18'h10000 - h;
    end
    if (res > 18'hFFFF) begin
      res = 18'hFFFF;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fvld_r   <= 1'b0;
      strobe_r <= 1'b0;
    end else begin
      fvld_r   <= e_vld;
      strobe_r <= fvld_r;
    end
  end

  assign busy            = 1'b0;
  assign out_strobe      = strobe_r;
  assign out_probability = prob_r;

endmodule

>>> rtl/ncdf_checker.sv
// ----------------------------------------------------------------------------
// ncdf_sva
// Port-level timing and value checks for normal_cdf_approx.
// ----------------------------------------------------------------------------
module ncdf_sva (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic signed [15:0] in_z_value,
  input logic               out_strobe,
  input logic [15:0]        out_probability
);
  import ncdf_pkg::*;

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##TOTAL_LAT out_strobe)
    else $error("no result after accepted transfer");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && !busy) |-> ##TOTAL_LAT !out_strobe)
    else $error("result without a transfer");

  a_zero_half: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_z_value == 16'sd0) |-> ##TOTAL_LAT
      (out_probability == 16'd32768))
    else $error("zero input did not give one half");

endmodule

bind normal_cdf_approx ncdf_sva u_ncdf_sva (.*);

>>> tb/ncdf_checker.sv
// ----------------------------------------------------------------------------
// ncdf_checker
// Watches the z and probability channels of the normal CDF block, predicts
// each probability with a fixed-point model and counts mismatches.
// ----------------------------------------------------------------------------
module ncdf_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic         busy,
  input  ncdf_pkg::z_t in_z_value,
  input  logic         out_strobe,
  input  logic [15:0]  out_probability,
  output int           fail_count,
  output int           pending_count,
  output int           result_count
);

  logic [15:0] prob_queue[$];

  // Round the magnitude of a*b to the given shift, then restore the sign.
  function automatic longint scaled_mul(longint a, longint unsigned b, int sh);
    logic neg;
    longint unsigned m;
    longint unsigned p;
    neg = a < 0;
    m = neg ? longint'(-a) : a;
    p = (m * b + (64'd1 << (sh - 1))) >> sh;
    return neg ? -longint'(p) : longint'(p);
  endfunction

  function automatic longint unsigned exp_neg(longint unsigned v24);
    longint unsigned n;
    longint unsigned r32;
    longint unsigned term;
    longint sum;
    n = v24 / 64'd11629080;
    r32 = (v24 - n * 64'd11629080) << 8;
    term = 64'd1 << 32;
    sum = 64'd1 << 32;
    for (int k = 1; k <= 12; k++) begin
      term = ((term * r32 + (64'd1 << 31)) >> 32) / k;
      if (k % 2 == 1) sum -= longint'(term);
      else sum += longint'(term);
    end
    if (sum < 0) sum = 0;
    if (n >= 40) return 0;
    return (longint'(sum) + ((64'd1 << n) >> 1)) >> n;
  endfunction

  function automatic logic [15:0] cdf_of(logic [15:0] z);
    logic neg;
    longint unsigned a, x24, px, den, t, x2, h, res;
    longint acc, q0, q;
    neg = z[15];
    a = neg ? 64'h10000 - z : z;
    x24 = (a * 64'd11863283 + 2048) >> 12;
    px = (x24 * 64'd5496067 + (64'd1 << 23)) >> 24;
    den = (64'd1 << 24) + px;
    t = ((64'd1 << 48) + (den >> 1)) / den;
    x2 = (x24 * x24 + (64'd1 << 23)) >> 24;
    acc = 17807428;
    acc = scaled_mul(acc, t, 24) - 24379845;
    acc = scaled_mul(acc, t, 24) + 23847365;
    acc = scaled_mul(acc, t, 24) - 4773063;
    acc = scaled_mul(acc, t, 24) + 4275331;
    q0 = scaled_mul(acc, t, 24);
    if (q0 < 0) q0 = 0;
    q = scaled_mul(q0, exp_neg(x2), 32);
    h = (longint'(q) + 256) >> 9;
    if (neg) res = h;
    else res = (h >= 65536) ? 0 : 65536 - h;
    if (res > 65535) res = 65535;
    return res[15:0];
  endfunction

  assign pending_count = prob_queue.size();

  always @(posedge clk) begin
    logic [15:0] want;
    if (!rst_n) begin
      fail_count <= 0;
      result_count <= 0;
      prob_queue.delete();
    end else begin
      if (start && !busy) prob_queue = {prob_queue, cdf_of(in_z_value)};
      if (out_strobe) begin
        result_count <= result_count + 1;
        if (prob_queue.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10)
            $display("unexpected result transfer: probability %0d", out_probability);
        end else begin
          want = prob_queue.pop_front();
          if (want !== out_probability) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display("probability mismatch: expected %0d got %0d", want,
                       out_probability);
          end
        end
      end
    end
  end

endmodule

>>> tb/tb_normal_cdf_approx.sv
// ----------------------------------------------------------------------------
// tb_normal_cdf_approx
// Drives directed and random z scores into the normal CDF block with random
// idle bursts; the checker predicts and compares every probability.
// ----------------------------------------------------------------------------
module tb_normal_cdf_approx;

  logic         clk;
  logic         rst_n;
  logic         start;
  logic         busy;
  ncdf_pkg::z_t in_z_value;
  logic         out_strobe;
  logic [15:0]  out_probability;
  int           fail_count;
  int           pending_count;
  int           result_count;
  int           sent_count;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  normal_cdf_approx u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_z_value(in_z_value), .out_strobe(out_strobe),
    .out_probability(out_probability)
  );

  ncdf_checker u_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_z_value(in_z_value), .out_strobe(out_strobe),
    .out_probability(out_probability), .fail_count(fail_count),
    .pending_count(pending_count), .result_count(result_count)
  );

  // Hold start high until the transfer happens.
  task automatic send_z(logic [15:0] z);
    start <= 1'b1;
    in_z_value <= z;
    @(posedge clk);
    while (busy) @(posedge clk);
    sent_count++;
    @(negedge clk);
  endtask

  task automatic idle_burst();
    start <= 1'b0;
    repeat ($urandom_range(1, 14)) @(negedge clk);
  endtask

  initial begin
    logic [15:0] directed[$] = '{16'h0000, 16'h0001, 16'hFFFF, 16'h7FFF, 16'h8000,
      16'h8001, 16'h1000, 16'hF000, 16'h2000, 16'hE000, 16'h4000, 16'hC000,
      16'h6000, 16'hA000, 16'h5555, 16'hAAAA, 16'h0800, 16'hF800, 16'h3000,
      16'hD000};
    logic [15:0] z;
    clk = 1'b0;
    rst_n = 1'b0;
    start = 1'b0;
    in_z_value = '0;
    sent_count = 0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    foreach (directed[i]) send_z(directed[i]);
    for (int i = 0; i < 800; i++) begin
      // Mostly the interesting range |z| <= 6, sometimes the full field.
      if ($urandom_range(0, 3) == 0) z = 16'($urandom);
      else z = 16'($signed($urandom_range(0, 49152)) - 24576);
      send_z(z);
      if (i < 650 && $urandom_range(0, 5) == 0) idle_burst();
    end
    start <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (60) @(negedge clk);
    $display("Sent %0d z scores (directed extremes and random), checked %0d results.",
             sent_count, result_count);
    if (fail_count == 0 && pending_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #500000;
    $display("Timeout after %0d results", result_count);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

>>> files.f
rtl/ncdf_pkg.sv
rtl/ncdf_front.sv
rtl/ncdf_recip.sv
rtl/ncdf_poly.sv
rtl/ncdf_exp.sv
rtl/normal_cdf_approx.sv
rtl/ncdf_checker.sv
tb/ncdf_checker.sv
tb/tb_normal_cdf_approx.sv
